FILE: src/tilt_vector_line_rasterizer_macros.svh
// Assertion macros used by the back end of the tilt vector line rasterizer RTL.
// The macros expect signals named clk and rst in the scope where they are used.
`ifndef TILT_VECTOR_LINE_RASTERIZER_MACROS_SVH
`define TILT_VECTOR_LINE_RASTERIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TVLR_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tvlr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TVLR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tvlr assertion failed");

`endif

FILE: src/tvlr_pkg.sv
// Shared types and constants for the tilt vector line rasterizer.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package tvlr_pkg;

  localparam int MAX_OFFSET_DEF  = 63;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_GAIN_X   = 3'd2,
    REG_GAIN_Y   = 3'd3,
    REG_LIMIT_X  = 3'd4,
    REG_LIMIT_Y  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] center_x;
    logic [4:0] center_y;
    logic [7:0] gain_x;
    logic [7:0] gain_y;
    logic [5:0] limit_x;
    logic [5:0] limit_y;
  } cfg_t;

  typedef struct packed {
    logic signed [8:0] cur_x;
    logic signed [8:0] cur_y;
    logic signed [8:0] end_x;
    logic signed [8:0] end_y;
    logic signed [8:0] err;
    logic        [6:0] abs_dx;
    logic signed [7:0] neg_abs_dy;
    logic        [1:0] signs;
  } job_t;

endpackage

`default_nettype wire

FILE: src/tilt_vector_line_rasterizer.sv
// Top level of the tilt vector line rasterizer: configuration registers and the
// front end, job queue and line walker. Depends on tvlr_pkg and the three submodules.
//
// Each accepted sample beat (accel_x, accel_y) becomes one line from the center to
// the scaled, clamped end point, sent as max(|dx|, |dy|) + 1 pixel beats, at most 64,
// with tlast on the end point. The front end registers the products when it takes a
// sample and builds the job from them, taking no new sample until the job has gone to
// the queue; the line walker then sends one pixel per cycle while the output side is
// ready. It takes a job only when idle, once the previous line's end point is out. A
// sample passes the product registers, queue, walker and output register. A queue of
// two jobs lets new samples be taken while a line is still being sent. Configuration
// writes are always ready and must only be made while no line is in progress.
`default_nettype none

module tilt_vector_line_rasterizer #(
  parameter int MAX_OFFSET  = tvlr_pkg::MAX_OFFSET_DEF,
  parameter int QUEUE_DEPTH = tvlr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [tvlr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [tvlr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [31:0]                       s_axis_tdata,  // accel_x [15:0], accel_y [31:16]
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [23:0]                      m_axis_tdata,  // pixel_x [8:0], pixel_y [16:9]
  output logic                             m_axis_tlast
);

  tvlr_pkg::cfg_t    cfg;
  tvlr_pkg::job_t    front_job;
  tvlr_pkg::job_t    queue_job;
  logic              front_valid;
  logic              front_ready;
  logic              queue_valid;
  logic              queue_ready;
  logic signed [8:0] pixel_x;
  logic signed [7:0] pixel_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= 7'd64;
      cfg.center_y <= 5'd16;
      cfg.gain_x   <= 8'd120;
      cfg.gain_y   <= 8'd80;
      cfg.limit_x  <= 6'd60;
      cfg.limit_y  <= 6'd40;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tvlr_pkg::REG_CENTER_X: cfg.center_x <= cfg_data[6:0];
        tvlr_pkg::REG_CENTER_Y: cfg.center_y <= cfg_data[4:0];
        tvlr_pkg::REG_GAIN_X:   cfg.gain_x   <= cfg_data;
        tvlr_pkg::REG_GAIN_Y:   cfg.gain_y   <= cfg_data;
        tvlr_pkg::REG_LIMIT_X:  cfg.limit_x  <= cfg_data[5:0];
        tvlr_pkg::REG_LIMIT_Y:  cfg.limit_y  <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  tvlr_front #(
    .MAX_OFFSET(MAX_OFFSET)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .accel_x   ($signed(s_axis_tdata[15:0])),
    .accel_y   ($signed(s_axis_tdata[31:16])),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  tvlr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_job   (front_job),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_job   (queue_job)
  );

  tvlr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (queue_valid),
    .job_ready  (queue_ready),
    .job        (queue_job),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, pixel_y, pixel_x};

endmodule

`default_nettype wire

FILE: src/tvlr_front.sv
// Front end: accepts samples, scales and clamps both axes, and builds a line job.
// Depends on tvlr_pkg for the configuration and job types.
`default_nettype none

module tvlr_front #(
  parameter int MAX_OFFSET = tvlr_pkg::MAX_OFFSET_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  tvlr_pkg::cfg_t           cfg,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire signed [15:0]        accel_x,
  input  wire signed [15:0]        accel_y,
  output logic                     job_valid,
  input  wire                      job_ready,
  output tvlr_pkg::job_t           job
);

  localparam int OFF_W = $clog2(MAX_OFFSET + 1);
  localparam logic [5:0] LIM_MAX = 6'(MAX_OFFSET);

  logic        p_valid;
  logic [23:0] prod_x;
  logic [23:0] prod_y;
  logic        neg_x;
  logic        neg_y;

  logic [15:0] mag_x;
  logic [15:0] mag_y;
  logic [5:0]  lim_x;
  logic [5:0]  lim_y;
  logic [OFF_W-1:0] off_x;
  logic [OFF_W-1:0] off_y;
  logic signed [8:0] cx;
  logic signed [8:0] cy;
  logic signed [8:0] ox9;
  logic signed [8:0] oy9;

  assign in_ready  = !p_valid;
  assign job_valid = p_valid;

  assign mag_x = accel_x[15] ? (~accel_x + 16'd1) : accel_x;
  assign mag_y = accel_y[15] ? (~accel_y + 16'd1) : accel_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      p_valid <= 1'b1;
    end else if (job_valid && job_ready) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_x <= {8'd0, mag_x} * {16'd0, cfg.gain_x};
      prod_y <= {8'd0, mag_y} * {16'd0, cfg.gain_y};
      neg_x  <= accel_x[15];
      neg_y  <= accel_y[15];
    end
  end

  always_comb begin
    lim_x = (cfg.limit_x > LIM_MAX) ? LIM_MAX : cfg.limit_x;
    lim_y = (cfg.limit_y > LIM_MAX) ? LIM_MAX : cfg.limit_y;
    off_x = (prod_x[23:16] > {2'b00, lim_x}) ? OFF_W'(lim_x) : OFF_W'(prod_x[23:16]);
    off_y = (prod_y[23:16] > {2'b00, lim_y}) ? OFF_W'(lim_y) : OFF_W'(prod_y[23:16]);
    cx    = $signed({2'b00, cfg.center_x});
    cy    = $signed({4'b0000, cfg.center_y});
    ox9   = $signed(9'(off_x));
    oy9   = $signed(9'(off_y));

    job.cur_x      = cx;
    job.cur_y      = cy;
    job.end_x      = neg_x ? (cx + ox9) : (cx - ox9);
    job.end_y      = neg_y ? (cy - oy9) : (cy + oy9);
    job.abs_dx     = 7'(off_x);
    job.neg_abs_dy = 8'sd0 - $signed(8'(off_y));
    job.err        = ox9 - oy9;
    job.signs[0]   = !(neg_x && (off_x != '0));
    job.signs[1]   = !(!neg_y && (off_y != '0));
  end

endmodule

`default_nettype wire

FILE: src/tvlr_queue.sv
// Short job queue between the front end and the line walker.
// Depends on tvlr_pkg for the job type.
`default_nettype none

module tvlr_queue #(
  parameter int DEPTH = tvlr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             wr_valid,
  output logic            wr_ready,
  input  tvlr_pkg::job_t  wr_job,
  output logic            rd_valid,
  input  wire             rd_ready,
  output tvlr_pkg::job_t  rd_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tvlr_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

endmodule

`default_nettype wire

FILE: src/tvlr_back.sv
// Back end: walks the Bresenham line of one job and emits one pixel per beat.
// Depends on tvlr_pkg and on the assertion macros header.
`default_nettype none
`include "tilt_vector_line_rasterizer_macros.svh"

module tvlr_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               job_valid,
  output logic              job_ready,
  input  tvlr_pkg::job_t    job,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [8:0] pixel_x,
  output logic signed [7:0] pixel_y,
  output logic              last_pixel
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t            state;
  logic signed [8:0] cur_x;
  logic signed [8:0] cur_y;
  logic signed [8:0] end_x;
  logic signed [8:0] end_y;
  logic signed [8:0] err;
  logic        [6:0] abs_dx;
  logic signed [7:0] neg_abs_dy;
  logic        [1:0] signs;

  logic              at_end;
  logic              emit;
  logic              load;
  logic signed [9:0] e2;
  logic              step_x;
  logic              step_y;
  logic signed [8:0] err_next;
  logic signed [8:0] cur_x_next;
  logic signed [8:0] cur_y_next;

  assign at_end    = (cur_x == end_x) && (cur_y == end_y);
  assign emit      = (state == ST_WALK) && (!out_valid || out_ready);
  assign job_ready = (state == ST_IDLE);
  assign load      = job_valid && job_ready;

  always_comb begin
    e2         = {err, 1'b0};
    step_x     = (e2 >= $signed({{2{neg_abs_dy[7]}}, neg_abs_dy}));
    step_y     = (e2 <= $signed({3'b000, abs_dx}));
    err_next   = err + (step_x ? $signed({neg_abs_dy[7], neg_abs_dy}) : 9'sd0)
                     + (step_y ? $signed({2'b00, abs_dx}) : 9'sd0);
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (step_x) begin
      cur_x_next = signs[0] ? (cur_x - 9'sd1) : (cur_x + 9'sd1);
    end
    if (step_y) begin
      cur_y_next = signs[1] ? (cur_y - 9'sd1) : (cur_y + 9'sd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (emit && at_end) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x    <= cur_x;
      pixel_y    <= cur_y[7:0];
      last_pixel <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_x      <= job.cur_x;
      cur_y      <= job.cur_y;
      end_x      <= job.end_x;
      end_y      <= job.end_y;
      err        <= job.err;
      abs_dx     <= job.abs_dx;
      neg_abs_dy <= job.neg_abs_dy;
      signs      <= job.signs;
    end else if (emit && !at_end) begin
      cur_x <= cur_x_next;
      cur_y <= cur_y_next;
      err   <= err_next;
    end
  end

  `TVLR_ASSERT_NEXT(a_last_ends_walk, emit && at_end, (state == ST_IDLE) && out_valid && last_pixel)
  `TVLR_ASSERT_NEXT(a_walk_moves, emit && !at_end, (cur_x != $past(cur_x)) || (cur_y != $past(cur_y)))
  `TVLR_ASSERT_NEXT(a_step_adjacent, emit && !at_end, (cur_x == $past(cur_x)) || (cur_x == $past(cur_x) + 9'sd1) || (cur_x == $past(cur_x) - 9'sd1))
  `TVLR_ASSERT_NEXT(a_stall_holds_walk, (state == ST_WALK) && out_valid && !out_ready, state == ST_WALK)

endmodule

`default_nettype wire
